// ===== src/vzd_pkg.sv =====
package vzd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned GroupW   = 7;
	localparam int unsigned ValueW   = 64;
	localparam int unsigned ZigzagW  = 32;
	localparam int unsigned WidthW   = 7;
	localparam int unsigned CountW   = 4;

	localparam logic [WidthW-1:0] WidthReset = 7'd32;
	localparam logic [WidthW-1:0] WidthMin   = 7'd1;
	localparam logic [WidthW-1:0] WidthMax   = 7'd64;
	localparam logic [WidthW-1:0] GroupStep  = 7'd7;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EXCESS = 2'd1,
		ST_ZERO   = 2'd2,
		ST_GROUPS = 2'd3
	} status_t;

	typedef struct packed {
		logic [ValueW-1:0]         value;
		logic signed [ZigzagW-1:0] zigzag_value;
		status_t                   status;
		logic [CountW-1:0]         byte_count;
	} result_t;

endpackage

// ===== src/vzd_byte_if.sv =====
interface vzd_byte_if
	import vzd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ByteW-1:0]  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/vzd_result_if.sv =====
interface vzd_result_if
	import vzd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [ValueW-1:0]         value;
	logic signed [ZigzagW-1:0] zigzag_value;
	status_t                   status;
	logic [CountW-1:0]         byte_count;

	modport source (output valid, output value, output zigzag_value, output status,
		output byte_count, input ready);
	modport sink   (input valid, input value, input zigzag_value, input status,
		input byte_count, output ready);
endinterface

// ===== src/varint_zigzag_decoder_core.sv =====
// a byte is held in the input register, then its result in the result register
// throughput: one byte per cycle while results are taken; the decode state is updated in the same cycle
//   the byte leaves the input register, so back-to-back bytes never wait on it
// reset: arst_n clears both valid flags and the decode state; value_bits returns to 32
// results stall back to the input only while the result register is full and not taken
module varint_zigzag_decoder_core
	import vzd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [WidthW-1:0] cfg_data,
	vzd_byte_if.sink          bytes,
	vzd_result_if.source      results
);

	logic [WidthW-1:0] value_bits_q;
	logic [ValueW-1:0] acc_q;
	logic [WidthW-1:0] shift_q;
	logic [CountW-1:0] bytes_q;

	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;

	logic              valid_s2;
	result_t           res_s2;

	logic              advance;
	logic              fire;

	logic [WidthW-1:0] bits;
	logic [WidthW-1:0] remain;
	logic [WidthW-1:0] shift_next;
	logic [GroupW-1:0] payload;
	logic              more;
	logic [CountW-1:0] count;
	logic              excess;
	logic [ValueW-1:0] acc_next;
	logic              emit;
	status_t           status;
	logic [ValueW-1:0] value;
	logic [ZigzagW-1:0] low;

	assign advance = !valid_s2 || results.ready;
	assign fire = valid_s1 && advance;
	assign bytes.ready = !valid_s1 || advance;

	always_comb begin
		if (value_bits_q < WidthMin) begin
			bits = WidthMin;
		end else if (value_bits_q > WidthMax) begin
			bits = WidthMax;
		end else begin
			bits = value_bits_q;
		end
	end

	assign payload = byte_s1[GroupW-1:0];
	assign more = byte_s1[ByteW-1];
	assign count = bytes_q + CountW'(1);
	assign remain = bits - shift_q;
	assign shift_next = shift_q + GroupStep;
	// fewer than seven bits left: payload must fit in what remains
	assign excess = (remain < GroupStep) && ((payload >> remain[2:0]) != '0);
	assign acc_next = acc_q | (ValueW'(payload) << shift_q[5:0]);

	always_comb begin
		emit = 1'b1;
		status = ST_OK;
		value = '0;
		if (shift_q >= bits) begin
			status = ST_GROUPS;
		end else if (excess) begin
			status = ST_EXCESS;
		end else if (!more) begin
			if (count != CountW'(1) && payload == '0) begin
				status = ST_ZERO;
			end else begin
				value = acc_next;
			end
		end else if (shift_next >= bits) begin
			status = ST_GROUPS;
		end else begin
			emit = 1'b0;
		end
	end

	assign low = value[ZigzagW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_bits_q <= WidthReset;
		end else if (cfg_wen) begin
			value_bits_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			shift_q <= '0;
			bytes_q <= '0;
		end else if (fire) begin
			if (emit) begin
				acc_q <= '0;
				shift_q <= '0;
				bytes_q <= '0;
			end else begin
				acc_q <= acc_next;
				shift_q <= shift_next;
				bytes_q <= count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_s2.value <= value;
			res_s2.zigzag_value <= (low >> 1) ^ {ZigzagW{low[0]}};
			res_s2.status <= status;
			res_s2.byte_count <= count;
		end
	end

	assign results.valid = valid_s2;
	assign results.value = res_s2.value;
	assign results.zigzag_value = res_s2.zigzag_value;
	assign results.status = res_s2.status;
	assign results.byte_count = res_s2.byte_count;

	// an error result never carries a value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status != ST_OK |-> results.value == '0
			&& results.zigzag_value == '0)
		else $error("error result with nonzero value");

	// any result restarts decoding
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> shift_q == '0 && bytes_q == '0 && acc_q == '0)
		else $error("decode state not cleared after result");

	// group position stays on a group boundary inside 64 bits
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q <= WidthMax - 1)
		else $error("group position out of range");

	// a result reports between one and ten bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.byte_count >= CountW'(1)
			&& results.byte_count <= CountW'(10))
		else $error("byte count out of range");

endmodule

// ===== dv/testbench.sv =====
module testbench;
	import vzd_pkg::*;

	localparam int QuietLimit  = 500;
	localparam int PhaseBytes  = 85;
	localparam int SettleTicks = 4;

	typedef struct {
		logic [ByteW-1:0] b;
		bit               typed;
		result_t          res;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [WidthW-1:0] cfg_data;

	vzd_byte_if   byte_ch();
	vzd_result_if result_ch();

	varint_zigzag_decoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_data (cfg_data),
		.bytes    (byte_ch),
		.results  (result_ch)
	);

	// decoder model state
	logic [WidthW-1:0] width_cfg;
	logic [ValueW-1:0] partial_acc;
	int                group_pos;
	logic [CountW-1:0] bytes_in_value;

	result_t          decoded_q[$];
	stim_row_t        stim_table[$];
	logic [ByteW-1:0] seq_q[$];
	result_t          want;

	bit bursts_on;
	int failures;
	int bytes_sent;
	int results_seen;
	int widths_used;
	int quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int eff_width(input logic [WidthW-1:0] w);
		if (w < WidthMin)
			return WidthMin;
		if (w > WidthMax)
			return WidthMax;
		return w;
	endfunction

	function automatic void clear_value();
		partial_acc    = '0;
		group_pos      = 0;
		bytes_in_value = '0;
	endfunction

	function automatic bit decode_byte(input logic [ByteW-1:0] b, output result_t r);
		logic [GroupW-1:0] payload;
		logic              more;
		int                bits;
		int                pos;
		logic [CountW-1:0] cnt;
		logic [31:0]       low;
		payload = b[GroupW-1:0];
		more    = b[ByteW-1];
		bits    = eff_width(width_cfg);
		pos     = group_pos;
		cnt     = bytes_in_value + 4'd1;
		r       = '0;
		r.byte_count = cnt;
		if (pos >= bits) begin
			r.status = ST_GROUPS;
			clear_value();
			return 1'b1;
		end
		// last group may only fill what is left of the width
		if (bits - pos < GroupW && int'(payload) >= (1 << (bits - pos))) begin
			r.status = ST_EXCESS;
			clear_value();
			return 1'b1;
		end
		partial_acc = partial_acc | (ValueW'(payload) << pos);
		if (!more) begin
			if (cnt != 4'd1 && payload == '0) begin
				r.status = ST_ZERO;
			end else begin
				low            = partial_acc[31:0];
				r.value        = partial_acc;
				r.zigzag_value = (low >> 1) ^ {32{low[0]}};
			end
			clear_value();
			return 1'b1;
		end
		pos += GroupStep;
		if (pos >= bits) begin
			r.status = ST_GROUPS;
			clear_value();
			return 1'b1;
		end
		group_pos      = pos;
		bytes_in_value = cnt;
		return 1'b0;
	endfunction

	function automatic void add_row(input logic [7:0] b, input bit typed,
		input logic [63:0] v, input logic [31:0] zz, input status_t st, input logic [3:0] cnt);
		stim_row_t row;
		row.b                = b;
		row.typed            = typed;
		row.res.value        = v;
		row.res.zigzag_value = zz;
		row.res.status       = st;
		row.res.byte_count   = cnt;
		stim_table.insert(stim_table.size(), row);
	endfunction

	task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input result_t res);
		result_t pred;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		bytes_sent++;
		if (decode_byte(b, pred))
			decoded_q.insert(decoded_q.size(), typed ? res : pred);
	endtask

	task automatic drain();
		byte_ch.valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SettleTicks) @(posedge clk);
	endtask

	task automatic write_width(input logic [WidthW-1:0] w);
		cfg_wen  <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		width_cfg  = w;
		widths_used++;
	endtask

	// mostly well-formed values, some with a broken last group, some noise
	task automatic build_sequence();
		int                bits;
		int                max_groups;
		int                n;
		int                rem;
		int                top;
		int                i;
		int                mode;
		logic [GroupW-1:0] p;
		seq_q.delete();
		bits       = eff_width(width_cfg);
		max_groups = (bits + GroupW - 1) / GroupW;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) seq_q.insert(seq_q.size(), ByteW'($urandom));
			return;
		end
		n = $urandom_range(1, max_groups);
		if ($urandom_range(0, 3) == 0)
			n = max_groups;
		for (i = 0; i < n - 1; i++) begin
			p = ($urandom_range(0, 3) == 0) ? 7'h7f : GroupW'($urandom);
			seq_q.insert(seq_q.size(), {1'b1, p});
		end
		rem = bits - GroupW * (n - 1);
		top = (rem >= GroupW) ? 127 : (1 << rem) - 1;
		p   = GroupW'($urandom_range((n > 1) ? 1 : 0, top));
		if ($urandom_range(0, 3) == 0)
			p = GroupW'(top);
		mode = $urandom_range(0, 9);
		if (mode == 7)
			p = '0;
		else if (mode == 8)
			p = GroupW'($urandom_range(top, 127));
		if (mode == 9) begin
			seq_q.insert(seq_q.size(), {1'b1, p});
			seq_q.insert(seq_q.size(), ByteW'($urandom));
		end else begin
			seq_q.insert(seq_q.size(), {1'b0, p});
		end
	endtask

	// result side: random stalls while bursts are on
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (bursts_on && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: value %0h status %0d",
					result_ch.value, result_ch.status);
				failures++;
			end else begin
				want = decoded_q.pop_front();
				if (result_ch.value !== want.value) begin
					$error("value: expected %0h, got %0h", want.value, result_ch.value);
					failures++;
				end
				if (result_ch.zigzag_value !== want.zigzag_value) begin
					$error("zigzag_value: expected %0d, got %0d",
						want.zigzag_value, result_ch.zigzag_value);
					failures++;
				end
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_ch.status);
					failures++;
				end
				if (result_ch.byte_count !== want.byte_count) begin
					$error("byte_count: expected %0d, got %0d",
						want.byte_count, result_ch.byte_count);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("watchdog: no handshake for %0d cycles", QuietLimit);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int      widths[$];
		int      k;
		int      phase_count;
		result_t none;
		widths = '{64, 1, 0, 127, 65, 7, 8, 13, 32, 63, -1, 64};
		none   = '0;

		arst_n          = 1'b0;
		cfg_wen         = 1'b0;
		cfg_data        = '0;
		byte_ch.valid   = 1'b0;
		byte_ch.in_byte = '0;
		bursts_on       = 1'b1;
		failures        = 0;
		bytes_sent      = 0;
		results_seen    = 0;
		widths_used     = 0;
		quiet_cycles    = 0;
		width_cfg       = WidthReset;
		clear_value();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width 32 after reset
		add_row(8'h00, 1, 64'd0,          32'sd0,         ST_OK,     4'd1);
		add_row(8'h7f, 1, 64'd127,        -32'sd64,       ST_OK,     4'd1);
		add_row(8'h01, 1, 64'd1,          -32'sd1,        ST_OK,     4'd1);
		add_row(8'h02, 1, 64'd2,          32'sd1,         ST_OK,     4'd1);
		// two-byte value ending in a zero group
		add_row(8'h80, 0, '0, '0, ST_OK, '0);
		add_row(8'h00, 1, 64'd0,          32'sd0,         ST_ZERO,   4'd2);
		add_row(8'hac, 0, '0, '0, ST_OK, '0);
		add_row(8'h02, 0, '0, '0, ST_OK, '0);
		// largest 32-bit value
		repeat (4) add_row(8'hff, 0, '0, '0, ST_OK, '0);
		add_row(8'h0f, 1, 64'hffff_ffff,  32'h8000_0000, ST_OK,     4'd5);
		// final group sets a bit above the width
		repeat (4) add_row(8'hff, 0, '0, '0, ST_OK, '0);
		add_row(8'h10, 1, 64'd0,          32'sd0,         ST_EXCESS, 4'd5);
		// continuation past the width
		repeat (4) add_row(8'hff, 0, '0, '0, ST_OK, '0);
		add_row(8'h8f, 1, 64'd0,          32'sd0,         ST_GROUPS, 4'd5);
		for (k = 0; k < stim_table.size(); k++)
			send_byte(stim_table[k].b, stim_table[k].typed, stim_table[k].res);

		// width lowered while a value is half done
		repeat (3) send_byte(8'h80, 0, none);
		drain();
		write_width(7'd8);
		send_byte(8'h05, 0, none);

		phase_count = widths.size();
		for (k = 0; k < phase_count; k++) begin
			drain();
			if (k == phase_count - 1)
				bursts_on = 1'b0;
			write_width(widths[k] < 0 ? WidthW'($urandom_range(1, 64)) : WidthW'(widths[k]));
			while (bytes_sent < stim_table.size() + 4 + (k + 1) * PhaseBytes) begin
				build_sequence();
				foreach (seq_q[j])
					send_byte(seq_q[j], 0, none);
				// hold the sender until the pipeline is empty now and then
				if ($urandom_range(0, 29) == 0)
					drain();
			end
		end
		drain();
		repeat (8) @(posedge clk);

		$display("sent %0d bytes under %0d width settings (0, 1, 7, 64 and above 64 among them)",
			bytes_sent, widths_used);
		$display("compared %0d results, %0d field mismatches", results_seen, failures);
		if (failures == 0 && decoded_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
